FILE: hw/rtl/mpfd_pkg.sv
// shared types, field widths and action codes of the framebuffer drawer
`default_nettype none
package mpfd_pkg;

   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 64;

   // coordinate widths wide enough for start plus span at the largest screen
   localparam int XW  = 9;
   localparam int YW  = 8;
   localparam int PGW = YW - 3;

   localparam logic [2:0] ACT_PIXEL   = 3'd0;
   localparam logic [2:0] ACT_VLINE   = 3'd1;
   localparam logic [2:0] ACT_HLINE   = 3'd2;
   localparam logic [2:0] ACT_RECT    = 3'd3;
   localparam logic [2:0] ACT_FILL    = 3'd4;
   localparam logic [2:0] ACT_PATTERN = 3'd5;
   localparam logic [2:0] ACT_CLEAR   = 3'd6;
   localparam logic [2:0] ACT_READ    = 3'd7;

   localparam logic [1:0] COLOR_CLEAR = 2'd0;
   localparam logic [1:0] COLOR_SET   = 2'd1;

   localparam logic [1:0] SEG_TOP    = 2'd0;
   localparam logic [1:0] SEG_BOTTOM = 2'd1;
   localparam logic [1:0] SEG_LEFT   = 2'd2;
   localparam logic [1:0] SEG_RIGHT  = 2'd3;

   typedef struct packed {
      logic [2:0] action;
      logic [6:0] x;
      logic [5:0] y;
      logic [7:0] span_w;
      logic [6:0] span_h;
      logic [1:0] color;
      logic [7:0] pattern;
      logic [9:0] read_index;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       clipped;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       load;
      logic       rd;
      logic       wr;
      logic       step;
      logic       clr;
      logic       read;
      logic       rsp_load;
      logic [1:0] seg;
   } dp_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic is_read;
      logic is_outline;
      logic draw_ok;
      logic last;
      logic clr_last;
   } dp_sts_type;

endpackage
`default_nettype wire

FILE: hw/rtl/mpfd_ctrl.sv
// controller state machine of the framebuffer drawer
`default_nettype none
module mpfd_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mpfd_pkg::dp_cmd_type      cmd,
   input  wire mpfd_pkg::dp_sts_type sts
);

   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_DEC  = 3'd2;
   localparam logic [2:0] ST_LOAD = 3'd3;
   localparam logic [2:0] ST_RD   = 3'd4;
   localparam logic [2:0] ST_WR   = 3'd5;
   localparam logic [2:0] ST_READ = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] seg_ff, seg_in;
   logic       clr_rsp_ff, clr_rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       more_seg;

   assign more_seg  = sts.is_outline && (seg_ff != mpfd_pkg::SEG_RIGHT);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.seg      = seg_ff;
      state_in     = state_ff;
      seg_in       = seg_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in   = clr_rsp_ff ? ST_DONE : ST_IDLE;
               clr_rsp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               seg_in      = mpfd_pkg::SEG_TOP;
               state_in    = ST_DEC;
            end
         end
         ST_DEC: begin
            if (sts.is_clear) begin
               clr_rsp_in = 1'b1;
               state_in   = ST_CLR;
            end else if (sts.is_read) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (sts.draw_ok) begin
               state_in = ST_RD;
            end else if (more_seg) begin
               seg_in = seg_ff + 2'd1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            cmd.wr = 1'b1;
            if (!sts.last) begin
               cmd.step = 1'b1;
               state_in = ST_RD;
            end else if (more_seg) begin
               seg_in   = seg_ff + 2'd1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         seg_ff       <= mpfd_pkg::SEG_TOP;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/mpfd_datapath.sv
// datapath of the framebuffer drawer: frame store, walk registers, result
`default_nettype none
module mpfd_datapath #(
   parameter int SCREEN_WIDTH  = mpfd_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = mpfd_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mpfd_pkg::req_type    req_data,
   input  wire mpfd_pkg::dp_cmd_type cmd,
   output mpfd_pkg::dp_sts_type      sts,
   output mpfd_pkg::rsp_type         rsp_data
);

   localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
   localparam int DEPTH = SCREEN_WIDTH * PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = mpfd_pkg::XW;
   localparam int YW    = mpfd_pkg::YW;
   localparam int PGW   = mpfd_pkg::PGW;
   localparam logic [XW-1:0] SW_X = XW'(SCREEN_WIDTH);
   localparam logic [YW-1:0] SH_Y = YW'(SCREEN_HEIGHT);

   logic [7:0] mem [DEPTH];
   logic [7:0] mem_q_ff;

   mpfd_pkg::req_type req_ff;
   mpfd_pkg::rsp_type rsp_ff;
   logic              clip_ff, clip_in;
   logic              in_range_ff, in_range_in;

   logic [XW-1:0]  col_ff, x0_ff, xe_ff;
   logic [YW-1:0]  y0_ff, ye_ff;
   logic [PGW-1:0] page_ff;
   logic [AW-1:0]  base_ff, addr_ff, clr_ff;

   logic [XW-1:0] sx, ex, xe_new;
   logic [YW-1:0] sy, ey, ye_new;
   logic [7:0]    sw;
   logic [6:0]    sh;
   logic [AW-1:0] base_new;
   logic [7:0]    mask, wdata;
   logic [AW-1:0] wa, ra;
   logic          we, re;

   // clipping of the whole request, decided when it is taken
   always_comb begin
      logic [XW-1:0] xw_sum;
      logic [YW-1:0] yh_sum;
      logic          x_off, y_off, w_nz, h_nz, pc;
      xw_sum      = XW'(req_data.x) + XW'(req_data.span_w);
      yh_sum      = YW'(req_data.y) + YW'(req_data.span_h);
      x_off       = XW'(req_data.x) >= SW_X;
      y_off       = YW'(req_data.y) >= SH_Y;
      w_nz        = req_data.span_w != 8'd0;
      h_nz        = req_data.span_h != 7'd0;
      in_range_in = 32'(req_data.read_index) < DEPTH;
      pc          = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (req_data.pattern[7-i] && (x_off || ((YW'(req_data.y) + YW'(i)) >= SH_Y))) begin
            pc = 1'b1;
         end
      end
      case (req_data.action)
         mpfd_pkg::ACT_PIXEL:   clip_in = x_off || y_off;
         mpfd_pkg::ACT_VLINE:   clip_in = h_nz && (x_off || (yh_sum > SH_Y));
         mpfd_pkg::ACT_HLINE:   clip_in = w_nz && ((xw_sum > SW_X) || y_off);
         mpfd_pkg::ACT_RECT,
         mpfd_pkg::ACT_FILL:    clip_in = w_nz && h_nz && ((xw_sum > SW_X) || (yh_sum > SH_Y));
         mpfd_pkg::ACT_PATTERN: clip_in = pc;
         mpfd_pkg::ACT_READ:    clip_in = !in_range_in;
         default:               clip_in = 1'b0;
      endcase
   end

   // rectangle of the current segment
   always_comb begin
      sx = XW'(req_ff.x);
      sy = YW'(req_ff.y);
      sw = 8'd0;
      sh = 7'd0;
      case (req_ff.action)
         mpfd_pkg::ACT_PIXEL: begin
            sw = 8'd1;
            sh = 7'd1;
         end
         mpfd_pkg::ACT_VLINE: begin
            sw = 8'd1;
            sh = req_ff.span_h;
         end
         mpfd_pkg::ACT_HLINE: begin
            sw = req_ff.span_w;
            sh = 7'd1;
         end
         mpfd_pkg::ACT_RECT: begin
            case (cmd.seg)
               mpfd_pkg::SEG_TOP: begin
                  sw = req_ff.span_w;
                  sh = 7'd1;
               end
               mpfd_pkg::SEG_BOTTOM: begin
                  sy = YW'(req_ff.y) + YW'(req_ff.span_h) - YW'(1);
                  sw = req_ff.span_w;
                  sh = 7'd1;
               end
               mpfd_pkg::SEG_LEFT: begin
                  sw = 8'd1;
                  sh = req_ff.span_h;
               end
               default: begin
                  sx = XW'(req_ff.x) + XW'(req_ff.span_w) - XW'(1);
                  sw = 8'd1;
                  sh = req_ff.span_h;
               end
            endcase
            if (req_ff.span_w == 8'd0 || req_ff.span_h == 7'd0) begin
               sw = 8'd0;
            end
         end
         mpfd_pkg::ACT_FILL: begin
            sw = req_ff.span_w;
            sh = req_ff.span_h;
         end
         mpfd_pkg::ACT_PATTERN: begin
            sw = 8'd1;
            sh = 7'd8;
         end
         default: begin
            sw = 8'd0;
         end
      endcase
      ex       = sx + XW'(sw) - XW'(1);
      ey       = sy + YW'(sh) - YW'(1);
      xe_new   = (ex >= SW_X) ? SW_X - XW'(1) : ex;
      ye_new   = (ey >= SH_Y) ? SH_Y - YW'(1) : ey;
      base_new = AW'(int'(sy[YW-1:3]) * SCREEN_WIDTH);
   end

   // rows of the current byte that the segment covers
   always_comb begin
      logic [YW-1:0] r, rel;
      logic          hit;
      for (int b = 0; b < 8; b++) begin
         r   = {page_ff, 3'(b)};
         rel = r - y0_ff;
         hit = (r >= y0_ff) && (r <= ye_ff);
         if (req_ff.action == mpfd_pkg::ACT_PATTERN) begin
            hit = hit && req_ff.pattern[3'd7 - rel[2:0]];
         end
         mask[b] = hit;
      end
      wdata = (req_ff.color == mpfd_pkg::COLOR_SET) ? (mem_q_ff | mask) : (mem_q_ff & ~mask);
   end

   assign sts.is_clear   = req_ff.action == mpfd_pkg::ACT_CLEAR;
   assign sts.is_read    = req_ff.action == mpfd_pkg::ACT_READ;
   assign sts.is_outline = req_ff.action == mpfd_pkg::ACT_RECT;
   assign sts.draw_ok    = (sw != 8'd0) && (sh != 7'd0) && (sx < SW_X) && (sy < SH_Y)
                           && !req_ff.color[1];
   assign sts.last       = (col_ff == xe_ff) && (page_ff == ye_ff[YW-1:3]);
   assign sts.clr_last   = clr_ff == AW'(DEPTH - 1);

   assign we = cmd.wr || cmd.clr;
   assign wa = cmd.clr ? clr_ff : addr_ff;
   assign re = cmd.rd || (cmd.read && in_range_ff);
   assign ra = cmd.read ? AW'(req_ff.read_index) : addr_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= cmd.clr ? 8'd0 : wdata;
      end
      if (re) begin
         mem_q_ff <= mem[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr) begin
         clr_ff <= sts.clr_last ? '0 : clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff      <= req_data;
         clip_ff     <= clip_in;
         in_range_ff <= in_range_in;
      end
      if (cmd.load) begin
         col_ff  <= sx;
         x0_ff   <= sx;
         xe_ff   <= xe_new;
         y0_ff   <= sy;
         ye_ff   <= ye_new;
         page_ff <= sy[YW-1:3];
         base_ff <= base_new;
         addr_ff <= base_new + AW'(sx);
      end else if (cmd.step) begin
         if (col_ff == xe_ff) begin
            col_ff  <= x0_ff;
            page_ff <= page_ff + PGW'(1);
            base_ff <= base_ff + AW'(SCREEN_WIDTH);
            addr_ff <= base_ff + AW'(SCREEN_WIDTH) + AW'(x0_ff);
         end else begin
            col_ff  <= col_ff + XW'(1);
            addr_ff <= addr_ff + AW'(1);
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.read_data <= (sts.is_read && in_range_ff) ? mem_q_ff : 8'd0;
         rsp_ff.clipped   <= clip_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/mono_page_framebuffer_drawer.sv
// top level of the monochrome page framebuffer drawer
//
// usage: one drawing, clear or read request enters on req_valid/req_ready and
// gives exactly one response on rsp_valid/rsp_ready (read_data, clipped).
// the frame store is one single-port-write array of width*pages bytes; each
// touched byte is read and then written back; an outline draws its sides
// in turn (top, bottom, left, right). clear sweeps the store one byte per
// cycle; after reset the same sweep runs with req_ready low, and then the
// store reads all zeros. a read returns the byte at read_index, or zero and
// clipped when read_index lies outside the store.
// one request is worked at a time; the response sits in an output register,
// so the next request is taken while a response waits on a stalled receiver,
// and that request completes once the register is free.
`default_nettype none
module mono_page_framebuffer_drawer #(
   parameter int SCREEN_WIDTH  = mpfd_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = mpfd_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mpfd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mpfd_pkg::rsp_type      rsp_data
);

   mpfd_pkg::dp_cmd_type dp_cmd;
   mpfd_pkg::dp_sts_type dp_sts;

   mpfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   mpfd_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (dp_cmd),
      .sts      (dp_sts),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!dp_cmd.wr && !dp_cmd.clr))
      else $error("frame store written while idle");

   a_read_then_write: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.rd |=> dp_cmd.wr)
      else $error("byte read not followed by its write");
`endif

endmodule
`default_nettype wire

FILE: tb/mono_page_framebuffer_drawer_test.sv
// self-checking testbench of the monochrome page framebuffer drawer
`default_nettype none
module mono_page_framebuffer_drawer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = 128;
   localparam int H = 64;
   localparam int DEPTH = W * ((H + 7) / 8);
   localparam int REQ_BITS = $bits(mpfd_pkg::req_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mpfd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   mpfd_pkg::rsp_type rsp_data;

   mono_page_framebuffer_drawer uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [7:0] shadow_frame [DEPTH];
   mpfd_pkg::req_type pending_requests [$];
   mpfd_pkg::rsp_type expected_responses [$];
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit stimulus_done = 1'b0;
   bit hold_sender = 1'b0;

   function automatic bit plot_pixel(int px, int py, logic [1:0] color);
      int idx;
      if (px >= W || py >= H) return 1'b1;
      idx = px + (py / 8) * W;
      if (color == mpfd_pkg::COLOR_SET) shadow_frame[idx][py % 8] = 1'b1;
      else if (color == mpfd_pkg::COLOR_CLEAR) shadow_frame[idx][py % 8] = 1'b0;
      return 1'b0;
   endfunction

   function automatic bit paint_area(int x0, int y0, int w, int h, logic [1:0] color);
      bit clip;
      clip = 1'b0;
      for (int i = 0; i < w; i++)
         for (int j = 0; j < h; j++)
            clip |= plot_pixel(x0 + i, y0 + j, color);
      return clip;
   endfunction

   function automatic mpfd_pkg::rsp_type draw_command(mpfd_pkg::req_type r);
      mpfd_pkg::rsp_type o;
      int x, y, w, h;
      o = '0;
      x = int'(r.x); y = int'(r.y); w = int'(r.span_w); h = int'(r.span_h);
      case (r.action)
         mpfd_pkg::ACT_PIXEL: o.clipped = plot_pixel(x, y, r.color);
         mpfd_pkg::ACT_VLINE: o.clipped = paint_area(x, y, 1, h, r.color);
         mpfd_pkg::ACT_HLINE: o.clipped = paint_area(x, y, w, 1, r.color);
         mpfd_pkg::ACT_RECT: if (w != 0 && h != 0) begin
            o.clipped = paint_area(x, y, w, 1, r.color);
            o.clipped |= paint_area(x, y + h - 1, w, 1, r.color);
            o.clipped |= paint_area(x, y, 1, h, r.color);
            o.clipped |= paint_area(x + w - 1, y, 1, h, r.color);
         end
         mpfd_pkg::ACT_FILL: o.clipped = paint_area(x, y, w, h, r.color);
         mpfd_pkg::ACT_PATTERN:
            for (int i = 0; i < 8; i++)
               if (r.pattern[7 - i]) o.clipped |= plot_pixel(x, y + i, r.color);
         mpfd_pkg::ACT_CLEAR: for (int i = 0; i < DEPTH; i++) shadow_frame[i] = '0;
         default: if (r.read_index < DEPTH) o.read_data = shadow_frame[r.read_index];
            else o.clipped = 1'b1;
      endcase
      return o;
   endfunction

   function automatic mpfd_pkg::req_type make_request(logic [2:0] act, int x, int y, int w,
         int h, int color, int pat, int ridx);
      mpfd_pkg::req_type r;
      r.action = act; r.x = 7'(x); r.y = 6'(y); r.span_w = 8'(w); r.span_h = 7'(h);
      r.color = 2'(color); r.pattern = 8'(pat); r.read_index = 10'(ridx);
      return r;
   endfunction

   function automatic mpfd_pkg::req_type random_request();
      mpfd_pkg::req_type r;
      int k;
      r = mpfd_pkg::req_type'(REQ_BITS'({$urandom, $urandom}));
      k = int'($urandom_range(99));
      if (k < 20) r.action = mpfd_pkg::ACT_READ;
      else if (k < 22) r.action = mpfd_pkg::ACT_CLEAR;
      else if (k < 40) r.action = mpfd_pkg::ACT_PIXEL;
      else if (k < 50) r.action = mpfd_pkg::ACT_PATTERN;
      if ($urandom_range(3) != 0) r.color = 2'($urandom_range(1));
      if (r.action == mpfd_pkg::ACT_FILL || r.action == mpfd_pkg::ACT_RECT) begin
         if ($urandom_range(19) != 0) begin
            r.span_w = 8'($urandom_range(12));
            r.span_h = 7'($urandom_range(12));
         end
      end else if ($urandom_range(3) != 0) begin
         r.span_w = 8'($urandom_range(40));
         r.span_h = 7'($urandom_range(24));
      end
      if ($urandom_range(9) != 0) r.read_index = 10'($urandom_range(DEPTH - 1));
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_requests.size() != 0 && !hold_sender &&
               $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (req_valid && req_ready) expected_responses.push_back(draw_command(req_data));
      if (rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %p", rsp_data);
         end else begin
            mpfd_pkg::rsp_type e;
            e = expected_responses.pop_front();
            if (e.read_data !== rsp_data.read_data || e.clipped !== rsp_data.clipped) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic drain_requests();
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) shadow_frame[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      pending_requests.push_back(make_request(mpfd_pkg::ACT_READ, 5, 3, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_PIXEL, 0, 0, 0, 0, 1, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_PIXEL, 127, 63, 0, 0, 1, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 1023));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_VLINE, 10, 60, 0, 64, 1, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_VLINE, 11, 0, 0, 0, 1, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_HLINE, 100, 9, 128, 0, 1, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_HLINE, 0, 20, 128, 0, 3, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_RECT, 120, 58, 10, 8, 1, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_RECT, 3, 3, 0, 5, 1, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_FILL, 0, 0, 128, 64, 1, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 777));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_FILL, 4, 4, 5, 0, 0, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_FILL, 2, 2, 20, 20, 0, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_FILL, 0, 0, 8, 8, 2, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_PATTERN, 50, 60, 0, 0, 0, 255, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_PATTERN, 51, 60, 0, 0, 0, 8'h80, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 818));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 2));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(mpfd_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 130));
      drain_requests();
      hold_sender = 1'b1;
      while (expected_responses.size() != 0) @(posedge clock);
      hold_sender = 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 63 : (phase == 3) ? 29 : 0;
         recv_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 29 : 0;
         for (int n = 0; n < 382; n++) pending_requests.push_back(random_request());
         drain_requests();
      end
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      stimulus_done = 1'b1;
   end

   initial begin
      wait (stimulus_done);
      if (mismatch_count == 0 && expected_responses.size() == 0)
         $display("mono_page_framebuffer_drawer regression: pass");
      else
         $display("mono_page_framebuffer_drawer regression: fail");
      $finish;
   end

   initial begin
      #100ms;
      $display("mono_page_framebuffer_drawer regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
